>>> hw/rtl/spq_pkg.sv
// Package for the stable priority queue: defaults, request, status and mode codes,
// and the control struct for the minimum-search unit.
// Depends on nothing; spq_min_unit and stable_priority_queue import it.
package spq_pkg;

  localparam int unsigned DEPTH_DEF         = 16;
  localparam int unsigned VALUE_BITS_DEF    = 32;
  localparam int unsigned PRIORITY_BITS_DEF = 8;

  // request kind carried in s_axis_tuser
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // serve mode register
  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_PRIO = 1'b1;

  // result status carried in m_axis_tuser
  localparam logic [1:0] STATUS_ENQ   = 2'd0;
  localparam logic [1:0] STATUS_DEQ   = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;
  localparam logic [1:0] STATUS_FULL  = 2'd3;

  typedef struct packed {
    logic start;   // load the sample as the first candidate
    logic sample;  // take the sample if strictly smaller
  } min_ctl_t;

endpackage

>>> hw/rtl/stable_priority_queue.sv
// Stable priority queue, top level: request sequencer, entry store and result register.
// Depends on spq_pkg, spq_ram and spq_min_unit.
//
// Usage:
//   Requests enter on the s_axis channel; tuser is the request kind (enqueue or
//   dequeue), tdata holds the value (low bits) and the priority above it.
//   One result leaves on m_axis per request: tuser is the status, tdata holds the
//   dequeued value (zero otherwise) and, above it, the occupancy after the request.
//   cfg_we_i/cfg_wdata_i write the serve mode (0 FIFO, 1 lowest priority first);
//   write it only while no request is in flight.
// Request handling, with n entries held:
//   enqueue, or dequeue on an empty queue: result goes straight to the output register.
//   dequeue, FIFO mode: slot 0 leaves and every later entry moves up one slot.
//   dequeue, priority mode: scan all n slots, take the chosen slot (pick), close the gap.
//   All entries sit in one single-port-read RAM; the priority scan reads one slot
//   per cycle through the shared compare unit, and the gap is closed by moving
//   one entry per cycle through the same read port.
// Reset empties the queue and sets priority mode. A result waits in the output
//   register while m_axis_tready is low; a new request is taken only once that
//   register is free or being drained in the same cycle.
module stable_priority_queue #(
  parameter int unsigned DEPTH         = spq_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_BITS    = spq_pkg::VALUE_BITS_DEF,
  parameter int unsigned PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic cfg_we_i,
  input  logic cfg_wdata_i,

  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // [VALUE_BITS-1:0] in_value, then in_priority, zero pad to bytes
  input  logic [((VALUE_BITS+PRIORITY_BITS+7)/8)*8-1:0] s_axis_tdata,
  // [0] req_type
  input  logic s_axis_tuser,

  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // [VALUE_BITS-1:0] out_value, then occupancy, zero pad to bytes
  output logic [((VALUE_BITS+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0] m_axis_tuser
);
  import spq_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned ENT_W = VALUE_BITS + PRIORITY_BITS;
  localparam int unsigned OUT_W = ((VALUE_BITS + CNT_W + 7) / 8) * 8;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_LOAD  = 2'd2;
  localparam logic [1:0] ST_SHIFT = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      ptr_q, ptr_d;
  logic [CNT_W-1:0]      last_q, last_d;
  logic                  have_q, have_d;
  logic [IDX_W-1:0]      pick_q, pick_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic                  mode_q, mode_d;

  logic                  out_valid_q, out_valid_d;
  logic [1:0]            out_status_q, out_status_d;
  logic [VALUE_BITS-1:0] out_value_q, out_value_d;
  logic [CNT_W-1:0]      out_occ_q, out_occ_d;

  logic                  in_fire;
  logic                  out_load;
  logic [1:0]            load_status;
  logic [VALUE_BITS-1:0] load_value;
  logic [CNT_W-1:0]      load_occ;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [ENT_W-1:0]      ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [ENT_W-1:0]      ram_rdata;
  logic [VALUE_BITS-1:0] rd_value;
  logic [PRIORITY_BITS-1:0] rd_prio;

  min_ctl_t              min_ctl;
  logic [IDX_W-1:0]      best_idx;

  logic [CNT_W-1:0]      cnt_last;
  logic [CNT_W-1:0]      last_minus1;
  logic [VALUE_BITS-1:0] in_value;
  logic [PRIORITY_BITS-1:0] in_priority;

  assign in_value    = s_axis_tdata[VALUE_BITS-1:0];
  assign in_priority = s_axis_tdata[VALUE_BITS +: PRIORITY_BITS];
  assign rd_value    = ram_rdata[VALUE_BITS-1:0];
  assign rd_prio     = ram_rdata[VALUE_BITS +: PRIORITY_BITS];
  assign cnt_last    = cnt_q - CNT_W'(1);
  assign last_minus1 = last_q - CNT_W'(1);

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    last_d      = last_q;
    have_d      = have_q;
    pick_d      = pick_q;
    val_d       = val_q;
    mode_d      = cfg_we_i ? cfg_wdata_i : mode_q;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q[IDX_W-1:0];
    ram_wdata   = {in_priority, in_value};
    ram_raddr   = ptr_q[IDX_W-1:0];
    min_ctl     = '0;
    out_load    = 1'b0;
    load_status = STATUS_ENQ;
    load_value  = '0;
    load_occ    = cnt_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser == REQ_ENQ) begin
            out_load = 1'b1;
            if (cnt_q == CNT_W'(DEPTH)) begin
              load_status = STATUS_FULL;
            end else begin
              ram_we   = 1'b1;
              cnt_d    = cnt_q + CNT_W'(1);
              load_occ = cnt_q + CNT_W'(1);
            end
          end else if (cnt_q == '0) begin
            out_load    = 1'b1;
            load_status = STATUS_EMPTY;
          end else begin
            ptr_d   = '0;
            have_d  = 1'b0;
            pick_d  = '0;
            state_d = (mode_q == MODE_PRIO) ? ST_SCAN : ST_SHIFT;
          end
        end
      end
      ST_SCAN: begin
        // one slot a cycle through the compare unit
        ptr_d  = ptr_q + CNT_W'(1);
        have_d = 1'b1;
        last_d = ptr_q;
        if (have_q) begin
          min_ctl.start  = (last_q == '0);
          min_ctl.sample = (last_q != '0);
          if (last_q == cnt_last) begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        pick_d  = best_idx;
        ptr_d   = CNT_W'(best_idx);
        have_d  = 1'b0;
        state_d = ST_SHIFT;
      end
      ST_SHIFT: begin
        // read slot k, then write it back to slot k-1: younger entries move up
        ptr_d  = ptr_q + CNT_W'(1);
        have_d = 1'b1;
        last_d = ptr_q;
        if (have_q) begin
          if (last_q == CNT_W'(pick_q)) begin
            val_d = rd_value;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = last_minus1[IDX_W-1:0];
            ram_wdata = ram_rdata;
          end
          if (last_q == cnt_last) begin
            state_d     = ST_IDLE;
            have_d      = 1'b0;
            cnt_d       = cnt_last;
            out_load    = 1'b1;
            load_status = STATUS_DEQ;
            load_value  = (last_q == CNT_W'(pick_q)) ? rd_value : val_q;
            load_occ    = cnt_last;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_occ_d    = out_occ_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_status_d = load_status;
      out_value_d  = load_value;
      out_occ_d    = load_occ;
    end else if (m_axis_tready) begin
      out_valid_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ptr_q       <= '0;
      last_q      <= '0;
      have_q      <= 1'b0;
      mode_q      <= MODE_PRIO;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      last_q      <= last_d;
      have_q      <= have_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q       <= pick_d;
    val_q        <= val_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_occ_q    <= out_occ_d;
  end

  spq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  spq_min_unit #(
    .DEPTH         (DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_min (
    .clk_i      (clk_i),
    .ctl_i      (min_ctl),
    .prio_i     (rd_prio),
    .idx_i      (last_q[IDX_W-1:0]),
    .best_idx_o (best_idx)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_occ_q, out_value_q});
  assign m_axis_tuser  = out_status_q;

  // a result is never written over one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && !m_axis_tready))
    else $error("result register overwritten while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (load_status == STATUS_DEQ)) |=> (cnt_q == $past(cnt_last)))
    else $error("dequeue did not drop one entry");

  // the gap walk never reaches past the held entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SHIFT) && have_q) |-> ((last_q < cnt_q) && (CNT_W'(pick_q) < cnt_q)))
    else $error("shift walked beyond the held entries");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) |-> (cnt_q != '0))
    else $error("search or shift on an empty queue");

endmodule

>>> hw/rtl/spq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module spq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/spq_min_unit.sv
// Shared compare unit: keeps the smallest priority seen so far and its slot.
// Strict less-than, so the oldest slot wins among equals. Depends on spq_pkg.
module spq_min_unit #(
  parameter int unsigned DEPTH         = spq_pkg::DEPTH_DEF,
  parameter int unsigned PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                     clk_i,
  input  spq_pkg::min_ctl_t        ctl_i,
  input  logic [PRIORITY_BITS-1:0] prio_i,
  input  logic [$clog2(DEPTH)-1:0] idx_i,
  output logic [$clog2(DEPTH)-1:0] best_idx_o
);
  import spq_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic [PRIORITY_BITS-1:0] best_prio_q, best_prio_d;
  logic [IDX_W-1:0]         best_idx_q, best_idx_d;

  always_comb begin
    best_prio_d = best_prio_q;
    best_idx_d  = best_idx_q;
    if (ctl_i.start || (ctl_i.sample && (prio_i < best_prio_q))) begin
      best_prio_d = prio_i;
      best_idx_d  = idx_i;
    end
  end

  always_ff @(posedge clk_i) begin
    best_prio_q <= best_prio_d;
    best_idx_q  <= best_idx_d;
  end

  assign best_idx_o = best_idx_q;

endmodule
